@@ rtl/mlfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfs_pkg: shared types and constants of the marker/length frame splitter
// Field widths, result kinds, parser phases and register map.
// ----------------------------------------------------------------------------
package mlfs_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 15;
  localparam int unsigned KindW   = 2;
  localparam int unsigned LenFieldBits = 16;

  // configuration port
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;
  localparam logic        RegMaxPayloadIdx = 1'b0;

  // frame constants
  localparam logic [ByteW-1:0] FrameMarker      = 8'd128;
  localparam logic [LenW-1:0]  MinPayloadLength = 15'd3;
  localparam logic [LenW-1:0]  MaxPayloadReset  = 15'd4096;

  // result kinds
  localparam logic [KindW-1:0] KindPayload   = 2'd0;
  localparam logic [KindW-1:0] KindBadMarker = 2'd1;
  localparam logic [KindW-1:0] KindBadLength = 2'd2;

  // parser phases
  typedef enum logic [2:0] {
    PH_MARKER  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DROP    = 3'd4
  } phase_e;

endpackage

@@ rtl/mlfs_if.sv @@
// ----------------------------------------------------------------------------
// mlfs_if: valid/ready channels of the marker/length frame splitter
// Received byte channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface mlfs_rx_if;
  logic                            valid;
  logic                            ready;
  logic [mlfs_pkg::ByteW-1:0]      rx_byte;
  logic                            chunk_end;

  modport source (output valid, output rx_byte, output chunk_end, input ready);
  modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface mlfs_res_if;
  logic                            valid;
  logic                            ready;
  logic [mlfs_pkg::KindW-1:0]      result_kind;
  logic [mlfs_pkg::ByteW-1:0]      payload_byte;
  logic                            frame_last;
  logic [mlfs_pkg::LenW-1:0]       frame_length;

  modport source (output valid, output result_kind, output payload_byte,
                  output frame_last, output frame_length, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input frame_last, input frame_length, output ready);
endinterface

@@ rtl/marker_length_frame_splitter_core.sv @@
// ----------------------------------------------------------------------------
// marker_length_frame_splitter_core: start-byte, length-prefixed deframer
// Splits a byte stream into frames of marker, 16-bit length and payload.
// ----------------------------------------------------------------------------
// One received byte is taken per clock. Each byte is parsed in the cycle it
// is accepted and its result, if any, appears in the result register on the
// next cycle. The byte channel stays ready as long as the result register is
// empty or being emptied, so the stream is held off only in cycles where a
// result waits in the register and the result sink stalls. Errors (bad
// marker, length below 3 or above max_payload_length) give one result with
// zero payload fields; the rest of that receive chunk is then dropped.
// max_payload_length sits at byte address 0 of the APB port and should be
// written only while the block is idle.
module marker_length_frame_splitter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mlfs_pkg::ApbAddrW-1:0]     paddr,
  input  logic [mlfs_pkg::ApbDataW-1:0]     pwdata,
  output logic [mlfs_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  // streams
  mlfs_rx_if.sink                           rx_i,
  mlfs_res_if.source                        res_o
);

  // parser state
  mlfs_pkg::phase_e               phase_q, phase_d;
  logic [mlfs_pkg::ByteW-1:0]     len_lo_q, len_lo_d;
  logic [mlfs_pkg::LenW-1:0]      rem_q, rem_d;
  logic [mlfs_pkg::LenW-1:0]      cur_len_q, cur_len_d;
  logic [mlfs_pkg::LenW-1:0]      max_len_q;

  // result register
  logic                           res_valid_q;
  logic [mlfs_pkg::KindW-1:0]     res_kind_q;
  logic [mlfs_pkg::ByteW-1:0]     res_byte_q;
  logic                           res_last_q;
  logic [mlfs_pkg::LenW-1:0]      res_len_q;

  // combinational result of the current byte
  logic                           res_vld;
  logic [mlfs_pkg::KindW-1:0]     res_kind;
  logic [mlfs_pkg::ByteW-1:0]     res_byte;
  logic                           res_last;
  logic [mlfs_pkg::LenW-1:0]      res_len;

  logic                           in_ready;
  logic                           in_fire;
  logic                           cfg_wr;
  logic [mlfs_pkg::LenW-1:0]      raw_len;
  logic                           len_bad;
  logic [mlfs_pkg::LenW-1:0]      rem_dec;

  // handshake
  assign in_ready = !res_valid_q || res_o.ready;
  assign in_fire  = rx_i.valid && in_ready;
  assign rx_i.ready = in_ready;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
               && (paddr[mlfs_pkg::ApbAddrW-1] == mlfs_pkg::RegMaxPayloadIdx);
  assign prdata = (paddr[mlfs_pkg::ApbAddrW-1] == mlfs_pkg::RegMaxPayloadIdx)
                ? mlfs_pkg::ApbDataW'(max_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= mlfs_pkg::MaxPayloadReset;
    end else if (cfg_wr) begin
      max_len_q <= pwdata[mlfs_pkg::LenW-1:0];
    end
  end

  // length check on the high length byte; a set sign bit is a negative length
  assign raw_len = {rx_i.rx_byte[mlfs_pkg::ByteW-2:0], len_lo_q};
  assign len_bad = rx_i.rx_byte[mlfs_pkg::ByteW-1]
                || (raw_len < mlfs_pkg::MinPayloadLength)
                || (raw_len > max_len_q);

  // remaining count after this payload byte
  assign rem_dec = (rem_q != '0) ? rem_q - mlfs_pkg::LenW'(1) : rem_q;

  // next state
  always_comb begin
    phase_d   = phase_q;
    len_lo_d  = len_lo_q;
    rem_d     = rem_q;
    cur_len_d = cur_len_q;
    unique case (phase_q)
      mlfs_pkg::PH_MARKER: begin
        if (rx_i.rx_byte != mlfs_pkg::FrameMarker) begin
          phase_d = rx_i.chunk_end ? mlfs_pkg::PH_MARKER : mlfs_pkg::PH_DROP;
        end else begin
          phase_d = mlfs_pkg::PH_LEN_LO;
        end
      end
      mlfs_pkg::PH_LEN_LO: begin
        len_lo_d = rx_i.rx_byte;
        phase_d  = mlfs_pkg::PH_LEN_HI;
      end
      mlfs_pkg::PH_LEN_HI: begin
        if (len_bad) begin
          phase_d = rx_i.chunk_end ? mlfs_pkg::PH_MARKER : mlfs_pkg::PH_DROP;
        end else begin
          cur_len_d = raw_len;
          rem_d     = raw_len;
          phase_d   = mlfs_pkg::PH_PAYLOAD;
        end
      end
      mlfs_pkg::PH_PAYLOAD: begin
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          phase_d = mlfs_pkg::PH_MARKER;
        end
      end
      mlfs_pkg::PH_DROP: begin
        if (rx_i.chunk_end) begin
          phase_d = mlfs_pkg::PH_MARKER;
        end
      end
      default: begin
        phase_d = mlfs_pkg::PH_MARKER;
      end
    endcase
  end

  // result of the current byte
  always_comb begin
    res_vld  = 1'b0;
    res_kind = mlfs_pkg::KindPayload;
    res_byte = '0;
    res_last = 1'b0;
    res_len  = '0;
    unique case (phase_q)
      mlfs_pkg::PH_MARKER: begin
        if (rx_i.rx_byte != mlfs_pkg::FrameMarker) begin
          res_vld  = 1'b1;
          res_kind = mlfs_pkg::KindBadMarker;
        end
      end
      mlfs_pkg::PH_LEN_HI: begin
        if (len_bad) begin
          res_vld  = 1'b1;
          res_kind = mlfs_pkg::KindBadLength;
        end
      end
      mlfs_pkg::PH_PAYLOAD: begin
        res_vld  = 1'b1;
        res_byte = rx_i.rx_byte;
        res_last = (rem_dec == '0);
        res_len  = cur_len_q;
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mlfs_pkg::PH_MARKER;
      len_lo_q  <= '0;
      rem_q     <= '0;
      cur_len_q <= '0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      len_lo_q  <= len_lo_d;
      rem_q     <= rem_d;
      cur_len_q <= cur_len_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_ready) begin
      res_valid_q <= in_fire && res_vld;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_ready) begin
      res_kind_q <= res_kind;
      res_byte_q <= res_byte;
      res_last_q <= res_last;
      res_len_q  <= res_len;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.result_kind  = res_kind_q;
  assign res_o.payload_byte = res_byte_q;
  assign res_o.frame_last   = res_last_q;
  assign res_o.frame_length = res_len_q;

  // payload phase always has bytes left to come
  a_payload_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mlfs_pkg::PH_PAYLOAD |-> rem_q != '0)
    else $error("payload phase with zero bytes remaining");

  // an accepted frame length is never below the minimum
  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mlfs_pkg::PH_PAYLOAD |-> cur_len_q >= mlfs_pkg::MinPayloadLength)
    else $error("payload phase with too short frame length");

  // the last payload byte shows up marked and parsing returns to the marker
  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == mlfs_pkg::PH_PAYLOAD && rem_q == mlfs_pkg::LenW'(1)
    |=> res_o.valid && res_o.frame_last && phase_q == mlfs_pkg::PH_MARKER)
    else $error("final payload byte not marked");

  // chunk end while dropping resumes marker search
  a_drop_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == mlfs_pkg::PH_DROP && rx_i.chunk_end
    |=> phase_q == mlfs_pkg::PH_MARKER && !res_o.valid)
    else $error("drop did not end at chunk end");

  // error results carry zero payload fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.result_kind != mlfs_pkg::KindPayload
    |-> res_o.payload_byte == '0 && !res_o.frame_last && res_o.frame_length == '0)
    else $error("error result with nonzero payload fields");

endmodule
